// ----- sv/afrd_pkg.sv -----
// ----------------------------------------------------------------------------
// afrd_pkg
// Types and constants shared by the escaped API frame receiver.
// ----------------------------------------------------------------------------
package afrd_pkg;

  localparam logic [7:0] StartDelim = 8'h7E;
  localparam logic [7:0] EscMark    = 8'h7D;
  localparam logic [7:0] CheckGood  = 8'hFF;

  // Escaped codes and the bytes they stand for.
  localparam logic [7:0] EscXon     = 8'h31;
  localparam logic [7:0] RawXon     = 8'h11;
  localparam logic [7:0] EscXoff    = 8'h33;
  localparam logic [7:0] RawXoff    = 8'h13;
  localparam logic [7:0] EscDelim   = 8'h5E;
  localparam logic [7:0] EscEsc     = 8'h5D;

  // Position of the length bytes, counted after the byte is stored.
  localparam int unsigned LenHighCount = 2;
  localparam int unsigned LenLowCount  = 3;
  localparam int unsigned DataStartPos = 3;
  localparam int unsigned FrameOverhead = 4;

  typedef enum logic [1:0] {
    EvStored   = 2'd0,
    EvEscape   = 2'd1,
    EvDropped  = 2'd2,
    EvConflict = 2'd3
  } afrd_event_e;

  typedef struct packed {
    afrd_event_e event_res;
    logic [7:0]  data_byte;
    logic [7:0]  position;
    logic        frame_end;
    logic        checksum_ok;
    logic        bad_escape;
    logic        overflow_reset;
    logic [15:0] frame_length;
  } afrd_result_t;

endpackage

// ----- sv/afrd_if.sv -----
// ----------------------------------------------------------------------------
// afrd_rx_if / afrd_res_if
// Valid/ready channels of the frame receiver: raw bytes in, status out.
// ----------------------------------------------------------------------------
interface afrd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afrd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  position;
  logic        frame_end;
  logic        checksum_ok;
  logic        bad_escape;
  logic        overflow_reset;
  logic [15:0] frame_length;

  modport source (
    output valid, output event_res, output data_byte, output position,
    output frame_end, output checksum_ok, output bad_escape,
    output overflow_reset, output frame_length, input ready
  );
  modport sink (
    input valid, input event_res, input data_byte, input position,
    input frame_end, input checksum_ok, input bad_escape,
    input overflow_reset, input frame_length, output ready
  );
endinterface

// ----- sv/api_frame_receive_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// api_frame_receive_deframer_unit
// Escaped API frame receiver: one status result for every received byte.
// ----------------------------------------------------------------------------
// Each transfer on rx_i carries one raw serial byte and produces exactly one
// status transfer on res_o, in order. A byte is registered on entry, decoded
// in a single pass through afrd_step while the frame state updates, and the
// status lands in an output register. One byte can be taken every cycle while
// res_o is not stalling, limited only by the one-byte frame state loop.
// The input side keeps accepting while a finished result waits, as long as
// the output register drains in the same cycle.
module api_frame_receive_deframer_unit import afrd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  afrd_rx_if.sink   rx_i,
  afrd_res_if.source res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES + 1);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  afrd_result_t    out_q;
  afrd_result_t    step_res;

  logic            receiving_q, receiving_d;
  logic            escape_q, escape_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      len_high_q, len_high_d;
  logic [15:0]     decl_len_q, decl_len_d;
  logic [7:0]      sum_q, sum_d;

  logic advance;
  logic in_ready;

  assign advance  = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign rx_i.ready = in_ready;

  afrd_step #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_step (
    .byte_i      (in_byte_q),
    .receiving_i (receiving_q),
    .escape_i    (escape_q),
    .count_i     (count_q),
    .len_high_i  (len_high_q),
    .decl_len_i  (decl_len_q),
    .sum_i       (sum_q),
    .receiving_o (receiving_d),
    .escape_o    (escape_d),
    .count_o     (count_d),
    .len_high_o  (len_high_d),
    .decl_len_o  (decl_len_d),
    .sum_o       (sum_d),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      receiving_q <= 1'b0;
      escape_q    <= 1'b0;
      count_q     <= '0;
      len_high_q  <= '0;
      decl_len_q  <= '0;
      sum_q       <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        receiving_q <= receiving_d;
        escape_q    <= escape_d;
        count_q     <= count_d;
        len_high_q  <= len_high_d;
        decl_len_q  <= decl_len_d;
        sum_q       <= sum_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.event_res      = out_q.event_res;
  assign res_o.data_byte      = out_q.data_byte;
  assign res_o.position       = out_q.position;
  assign res_o.frame_end      = out_q.frame_end;
  assign res_o.checksum_ok    = out_q.checksum_ok;
  assign res_o.bad_escape     = out_q.bad_escape;
  assign res_o.overflow_reset = out_q.overflow_reset;
  assign res_o.frame_length   = out_q.frame_length;

  // The byte count never runs past the buffer capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= BUFFER_BYTES)
    else $error("byte count exceeds buffer capacity");

  // A completed frame is always reported on a stored byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.event_res == EvStored)
    else $error("frame end on a byte that was not stored");

  // A good checksum is only reported together with a frame end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.checksum_ok |-> out_q.frame_end)
    else $error("checksum flag without frame end");

  // Finishing a frame leaves the receiver idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_res.frame_end |=> !receiving_q)
    else $error("receiver still active after frame end");

endmodule

// ----- sv/afrd_step.sv -----
// ----------------------------------------------------------------------------
// afrd_step
// Next-state and status logic for one received byte.
// ----------------------------------------------------------------------------
module afrd_step import afrd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256,
  localparam int unsigned CntW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic [7:0]      byte_i,
  input  logic            receiving_i,
  input  logic            escape_i,
  input  logic [CntW-1:0] count_i,
  input  logic [7:0]      len_high_i,
  input  logic [15:0]     decl_len_i,
  input  logic [7:0]      sum_i,
  output logic            receiving_o,
  output logic            escape_o,
  output logic [CntW-1:0] count_o,
  output logic [7:0]      len_high_o,
  output logic [15:0]     decl_len_o,
  output logic [7:0]      sum_o,
  output afrd_result_t    res_o
);

  localparam int unsigned CmpW = (CntW > 17) ? CntW : 17;

  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] cnt_inc;
  logic [CmpW-1:0] limit_old;
  logic [CmpW-1:0] limit_new;
  logic [CntW-1:0] cnt_start;
  logic            recv_start;
  logic            esc_start;
  logic [15:0]     decl_start;
  logic [7:0]      b;
  logic            bad;
  logic [7:0]      sum_new;
  logic [15:0]     decl_new;

  always_comb begin
    // A full buffer drops the frame before the byte is looked at.
    res_o = '0;
    res_o.event_res = EvDropped;
    if (CmpW'(count_i) >= CmpW'(BUFFER_BYTES)) begin
      cnt_start  = '0;
      recv_start = 1'b0;
      esc_start  = 1'b0;
      decl_start = '0;
      res_o.overflow_reset = 1'b1;
    end else begin
      cnt_start  = count_i;
      recv_start = receiving_i;
      esc_start  = escape_i;
      decl_start = decl_len_i;
    end

    cnt_ext   = CmpW'(cnt_start);
    cnt_inc   = cnt_ext + CmpW'(1);
    limit_old = CmpW'(decl_start) + CmpW'(FrameOverhead);

    b   = byte_i;
    bad = 1'b0;
    if (esc_start) begin
      case (byte_i)
        EscXon:   b = RawXon;
        EscXoff:  b = RawXoff;
        EscDelim: b = StartDelim;
        EscEsc:   b = EscMark;
        default:  bad = 1'b1;
      endcase
    end

    sum_new = (cnt_ext >= CmpW'(DataStartPos)) ? sum_i + b : sum_i;
    decl_new = (cnt_inc == CmpW'(LenLowCount)) ? {len_high_i, b} : decl_start;
    limit_new = CmpW'(decl_new) + CmpW'(FrameOverhead);

    receiving_o = recv_start;
    escape_o    = esc_start;
    count_o     = cnt_start;
    len_high_o  = len_high_i;
    decl_len_o  = decl_start;
    sum_o       = sum_i;

    if (cnt_ext > limit_old) begin
      receiving_o     = 1'b0;
      escape_o        = 1'b0;
      count_o         = '0;
      decl_len_o      = '0;
      res_o.event_res = EvConflict;
    end else if (byte_i == StartDelim && !esc_start) begin
      receiving_o     = 1'b1;
      escape_o        = 1'b0;
      count_o         = CntW'(1);
      len_high_o      = '0;
      decl_len_o      = '0;
      sum_o           = '0;
      res_o.event_res = EvStored;
      res_o.data_byte = byte_i;
    end else if (byte_i == EscMark) begin
      escape_o        = 1'b1;
      res_o.event_res = EvEscape;
    end else if (recv_start) begin
      escape_o         = 1'b0;
      count_o          = cnt_inc[CntW-1:0];
      sum_o            = sum_new;
      decl_len_o       = decl_new;
      if (cnt_inc == CmpW'(LenHighCount)) begin
        len_high_o = b;
      end
      if (cnt_inc == limit_new) begin
        receiving_o       = 1'b0;
        res_o.frame_end   = 1'b1;
        res_o.checksum_ok = (sum_new == CheckGood);
      end
      res_o.event_res  = EvStored;
      res_o.data_byte  = b;
      res_o.position   = cnt_ext[7:0];
      res_o.bad_escape = bad;
    end
    res_o.frame_length = decl_len_o;
  end

endmodule

// ----- tb/afrd_status_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_status_checker
// Watches both channels of the frame receiver, predicts the status of every
// accepted byte and compares each status transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module afrd_status_checker import afrd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  afrd_rx_if   rx_mon,
  afrd_res_if  res_mon,
  output int   fail_count_o,
  output int   pending_o
);

  // Frame state as the receiver should hold it.
  logic        in_frame;
  logic        esc_armed;
  logic [16:0] stored_count;
  logic [7:0]  len_high;
  logic [15:0] frame_len;
  logic [7:0]  data_sum;

  afrd_result_t pending_status [$];
  afrd_result_t want;

  function automatic void clear_frame();
    stored_count = '0;
    in_frame     = 1'b0;
    frame_len    = '0;
    esc_armed    = 1'b0;
  endfunction

  function automatic afrd_result_t decode_byte(logic [7:0] raw);
    afrd_result_t st;
    logic [7:0]   b;
    st = '0;
    st.event_res = EvDropped;
    b = raw;
    // A buffer that is already full is dropped before the byte is looked at.
    if (stored_count >= BUFFER_BYTES) begin
      clear_frame();
      st.overflow_reset = 1'b1;
    end
    if (int'(stored_count) > int'(frame_len) + int'(FrameOverhead)) begin
      clear_frame();
      st.event_res = EvConflict;
    end else if (b == StartDelim && !esc_armed) begin
      frame_len    = '0;
      data_sum     = '0;
      len_high     = '0;
      in_frame     = 1'b1;
      esc_armed    = 1'b0;
      stored_count = 17'd1;
      st.event_res = EvStored;
      st.data_byte = b;
    end else if (b == EscMark) begin
      esc_armed    = 1'b1;
      st.event_res = EvEscape;
    end else if (in_frame) begin
      if (esc_armed) begin
        case (b)
          EscXon:   b = RawXon;
          EscXoff:  b = RawXoff;
          EscDelim: b = StartDelim;
          EscEsc:   b = EscMark;
          default:  st.bad_escape = 1'b1;
        endcase
        esc_armed = 1'b0;
      end
      st.position = stored_count[7:0];
      if (stored_count >= DataStartPos) data_sum = data_sum + b;
      stored_count = stored_count + 17'd1;
      if (stored_count == LenHighCount) len_high = b;
      if (stored_count == LenLowCount) frame_len = {len_high, b};
      if (int'(stored_count) == int'(frame_len) + int'(FrameOverhead)) begin
        in_frame        = 1'b0;
        st.frame_end    = 1'b1;
        st.checksum_ok  = (data_sum == CheckGood);
      end
      st.event_res = EvStored;
      st.data_byte = b;
    end
    st.frame_length = frame_len;
    return st;
  endfunction

  task automatic check_field(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_v,
               act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame     = 1'b0;
      esc_armed    = 1'b0;
      stored_count = '0;
      len_high     = '0;
      frame_len    = '0;
      data_sum     = '0;
      pending_status.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Compare first so that a result can never match a byte of the same cycle.
      if (res_mon.valid && res_mon.ready) begin
        if (pending_status.size() == 0) begin
          fail_count_o++;
          $display("%0t: status transfer with nothing expected, expected none, actual 0x%0h",
                   $time, {res_mon.event_res, res_mon.data_byte, res_mon.position});
        end else begin
          want = pending_status.pop_front();
          check_field("event_res", want.event_res, res_mon.event_res);
          check_field("data_byte", want.data_byte, res_mon.data_byte);
          check_field("position", want.position, res_mon.position);
          check_field("frame_end", want.frame_end, res_mon.frame_end);
          check_field("checksum_ok", want.checksum_ok, res_mon.checksum_ok);
          check_field("bad_escape", want.bad_escape, res_mon.bad_escape);
          check_field("overflow_reset", want.overflow_reset, res_mon.overflow_reset);
          check_field("frame_length", want.frame_length, res_mon.frame_length);
        end
      end
      if (rx_mon.valid && rx_mon.ready) pending_status.push_back(decode_byte(rx_mon.rx_byte));
      pending_o = pending_status.size();
    end
  end

endmodule

// ----- tb/api_frame_receive_deframer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_receive_deframer_unit_tb
// Feeds escaped frames, broken frames and line noise into the frame receiver
// with random gaps on both channels and lets the checker grade every status.
// ----------------------------------------------------------------------------
module api_frame_receive_deframer_unit_tb;
  import afrd_pkg::*;

  localparam int unsigned BufferBytes = 256;
  localparam int unsigned ByteTarget  = 1900;
  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned FullFrameLen = BufferBytes - FrameOverhead;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   pending;
  int   fail_count;
  int unsigned sent_bytes = 0;
  int unsigned cycle_count = 0;

  logic [7:0] opening_seq [$] = {
    // Idle bytes at both extremes are dropped.
    8'h00, 8'hFF,
    // Length 3 with legal escapes and a repeated marker; good checksum.
    StartDelim, 8'h00, 8'h03, EscMark, EscXon, EscMark, EscDelim,
    EscMark, EscMark, EscEsc, 8'hF3,
    // Length zero ends after four bytes.
    StartDelim, 8'h00, 8'h00, 8'hFF,
    // An escaped start delimiter is stored and flagged.
    StartDelim, 8'h00, 8'h01, EscMark, StartDelim, 8'h81
  };

  afrd_rx_if  rx_bus ();
  afrd_res_if res_bus ();

  api_frame_receive_deframer_unit #(
    .BUFFER_BYTES(BufferBytes)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_bus),
    .res_o (res_bus)
  );

  afrd_status_checker #(
    .BUFFER_BYTES(BufferBytes)
  ) status_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_mon      (rx_bus),
    .res_mon     (res_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    // Every third stretch of 150 bytes goes without gaps.
    gap = (((sent_bytes / 150) % 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.rx_byte <= value;
    rx_bus.valid   <= 1'b1;
    do @(posedge clk_i); while (!rx_bus.ready);
    sent_bytes++;
  endtask

  // Sends one stored byte in its line coding, so that the stored value stays
  // what the frame builder meant even when the escape is an illegal one.
  task automatic send_escaped(input logic [7:0] value);
    logic        escape_it;
    logic [7:0]  coded;
    int unsigned pick;
    coded = value;
    escape_it = 1'b0;
    case (value)
      EscMark: begin
        escape_it = 1'b1;
        coded = EscEsc;
      end
      StartDelim: begin
        escape_it = 1'b1;
        coded = ($urandom_range(0, 3) == 0) ? StartDelim : EscDelim;
      end
      RawXon, RawXoff: begin
        pick = $urandom_range(0, 2);
        escape_it = (pick != 0);
        if (pick == 1) coded = (value == RawXon) ? EscXon : EscXoff;
      end
      EscXon, EscXoff, EscDelim, EscEsc: ;
      default: escape_it = ($urandom_range(0, 19) == 0);
    endcase
    if (escape_it) begin
      if ($urandom_range(0, 7) == 0) send_byte(EscMark);
      send_byte(EscMark);
    end
    send_byte(coded);
  endtask

  // Sends the first keep stored bytes of a frame with the given length.
  task automatic send_frame(input int unsigned len, input bit sum_good,
                            input int unsigned keep);
    logic [7:0]  stored;
    logic [7:0]  data_sum;
    int unsigned total;
    total = len + FrameOverhead;
    data_sum = '0;
    send_byte(StartDelim);
    for (int unsigned i = 1; i < total && i < keep; i++) begin
      if (i == 1) begin
        stored = len[15:8];
      end else if (i == 2) begin
        stored = len[7:0];
      end else if (i < total - 1) begin
        stored = 8'($urandom);
        data_sum = data_sum + stored;
      end else begin
        stored = sum_good ? CheckGood - data_sum : 8'($urandom);
      end
      send_escaped(stored);
    end
  endtask

  task automatic drain_results();
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, gap-free stretches and one long hold-off
  // that backs the receiver up into its input.
  initial begin
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == 700) gap = 300;
      else gap = (((taken / 130) % 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      taken++;
    end
  end

  initial begin
    int unsigned frame_no;
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    logic [7:0]  noise;
    frame_no = 0;
    rst_ni <= 1'b0;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_seq[i]) send_byte(opening_seq[i]);
    drain_results();

    while (sent_bytes < ByteTarget) begin
      frame_no++;
      pick = $urandom_range(0, 99);
      if (frame_no == 2 || pick < 3) begin
        // Fills the buffer exactly; the byte after it sees the overflow.
        len  = FullFrameLen;
        keep = len + FrameOverhead;
      end else if (frame_no == 5 || pick < 6) begin
        // Longer than the buffer: cut at the capacity and let it overflow.
        len  = (frame_no == 5) ? 16'hFFFF : $urandom_range(FullFrameLen + 1, 16'hFFFF);
        keep = BufferBytes;
      end else begin
        len  = (pick < 20) ? $urandom_range(21, 60) : $urandom_range(0, 20);
        keep = (pick >= 92) ? $urandom_range(1, len + 3) : len + FrameOverhead;
      end
      send_frame(len, $urandom_range(0, 6) != 0, keep);
      // Line noise never carries a marker: a marker outside a frame would
      // leave the escape armed and lock out every later start delimiter.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          do noise = 8'($urandom); while (noise == EscMark);
          send_byte(noise);
        end
      end
      if (frame_no == 40) drain_results();
    end

    // A clean frame leaves the receiver idle; then a marker between frames
    // keeps the escape armed, so neither start delimiter opens a frame.
    send_frame(2, 1'b1, 6);
    send_byte(EscMark);
    send_byte(StartDelim);
    send_byte(8'h00);
    send_byte(StartDelim);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
